// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWERC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swerc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SWERC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swerc assertion failed");

`endif

// File: sv/swerc_pkg.sv
package swerc_pkg;

	localparam int CFG_W      = 7;
	localparam int TS_W       = 48;
	localparam int EVT_W      = 16;
	localparam int COUNT_W    = 32;
	localparam int ACC_W      = 40;
	localparam int SUM_W      = TS_W + 2;

	localparam int DEF_MAX_BINS  = 64;
	localparam int DEF_FRAC_BITS = 16;

	localparam logic [CFG_W-1:0] WIN_RESET = 7'd60;

	localparam logic KIND_PUSH  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// saturating add, used by the shared adder of the sequencer
	function automatic logic [COUNT_W-1:0] sat_add(
		input logic [COUNT_W-1:0] a,
		input logic [COUNT_W-1:0] b
	);
		logic [COUNT_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[COUNT_W] ? {COUNT_W{1'b1}} : t[COUNT_W-1:0];
	endfunction

endpackage

// File: sv/swerc_bin_ram.sv
module swerc_bin_ram import swerc_pkg::*; #(
	parameter int DEPTH  = DEF_MAX_BINS,
	parameter int IDX_W  = 6,
	parameter int DATA_W = COUNT_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/sliding_window_event_rate_counter.sv
// channel  | handshake              | word
// ---------+------------------------+--------------------------------------
// cfg      | cfg_valid / cfg_ready  | cfg_data: window length in seconds
// in       | in_valid / in_ready    | kind, timestamp, event_count
// out      | out_valid / out_ready  | window_count, one word per query
//
// push: elapsed time formed, then the oldest bin zeroed once per whole second advanced,
// no bins moved if time went back, all active bins wiped when a whole window passed;
// then the newest bin is read and written. query: bins still in the window summed,
// skipped when the answer is zero; waits while the previous word is still in the output register
// reset and each cfg write start a clearing pass over all MAX_BINS bins, in_ready low
// cfg words are taken only while idle; a waiting cfg word holds in_ready low
module sliding_window_event_rate_counter import swerc_pkg::*; #(
	parameter int MAX_BINS  = DEF_MAX_BINS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [TS_W-1:0]    timestamp,
	input  logic [EVT_W-1:0]   event_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] window_count
);

	// ring index and bin-count widths
	localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CNT_W = $clog2(MAX_BINS + 1);

	// fraction mask and minus one second in the elapsed-time format
	localparam logic [SUM_W-1:0] FRAC_MASK = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);
	localparam logic [SUM_W-1:0] NEG_ONE   = ~FRAC_MASK;
	// most negative accumulator value, sign extended
	localparam logic [SUM_W-1:0] ACC_MIN_X =
		{{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
	localparam logic [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ELAP,
		ST_DECIDE,
		ST_ADV,
		ST_WIPE,
		ST_NEWEST_RD,
		ST_NEWEST_WR,
		ST_QSUM,
		ST_QOUT
	} state_t;

	// window register clamps to 1..MAX_BINS
	function automatic logic [CNT_W-1:0] win_clamp(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return CNT_W'(1);
		end else if (int'(v) > MAX_BINS) begin
			return CNT_W'(MAX_BINS);
		end else begin
			return CNT_W'(v);
		end
	endfunction

	state_t               state_q;
	logic [CNT_W-1:0]     win_q;
	logic [IDX_W-1:0]     oldest_q;   // ring position of the oldest bin
	logic [ACC_W-1:0]     acc_q;      // signed time since the newest bin opened
	logic [TS_W-1:0]      last_q;     // timestamp of the last push
	logic [IDX_W-1:0]     pos_q;      // walking ram address
	logic [CNT_W-1:0]     rem_q;      // bins still to visit
	logic                 pend_q;     // a read word lands this cycle
	logic                 kind_q;
	logic [TS_W-1:0]      ts_q;
	logic [EVT_W-1:0]     cnt_q;
	logic [TS_W:0]        diff_q;     // timestamp minus last push, signed
	logic [SUM_W-1:0]     sum_q;      // elapsed time, signed
	logic [COUNT_W-1:0]   total_q;
	logic                 out_valid_q;
	logic [COUNT_W-1:0]   out_data_q;

	// decode of the elapsed time
	logic                 sum_neg;
	logic                 whole_ge;
	logic                 past_second;
	logic [CNT_W-1:0]     whole_w;
	logic [CNT_W-1:0]     skip_w;
	logic [CNT_W:0]       start_sum;
	logic [CNT_W:0]       start_fix;
	logic [IDX_W-1:0]     start_pos;
	logic [ACC_W-1:0]     acc_neg;
	logic [ACC_W-1:0]     acc_frac;

	// ring stepping
	logic [IDX_W-1:0]     oldest_next;
	logic [IDX_W-1:0]     pos_next;
	logic [IDX_W-1:0]     newest_idx;

	// finished query word moves into the output register
	logic                 out_load;

	// shared saturating adder
	logic [COUNT_W-1:0]   add_a;
	logic [COUNT_W-1:0]   add_b;
	logic [COUNT_W-1:0]   add_y;

	// bin ram ports
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [COUNT_W-1:0]   ram_wdata;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [COUNT_W-1:0]   ram_rdata;

	always_comb begin
		sum_neg     = sum_q[SUM_W-1];
		whole_ge    = (sum_q >> FRAC_BITS) >= SUM_W'(win_q);
		past_second = $signed(sum_q) <= $signed(NEG_ONE);
		whole_w     = sum_q[FRAC_BITS +: CNT_W];
		skip_w      = sum_neg ? '0 : whole_w;
		// first bin still in the window: oldest plus age, wrapped once
		start_sum   = {1'b0, CNT_W'(oldest_q)} + {1'b0, skip_w};
		start_fix   = (start_sum >= {1'b0, win_q}) ? start_sum - {1'b0, win_q} : start_sum;
		start_pos   = IDX_W'(start_fix);
		acc_neg     = ($signed(sum_q) < $signed(ACC_MIN_X)) ? ACC_MIN : sum_q[ACC_W-1:0];
		acc_frac    = sum_q[ACC_W-1:0] & FRAC_MASK[ACC_W-1:0];

		oldest_next = (CNT_W'(oldest_q) == win_q - CNT_W'(1)) ? '0 : oldest_q + IDX_W'(1);
		pos_next    = (CNT_W'(pos_q) == win_q - CNT_W'(1)) ? '0 : pos_q + IDX_W'(1);
		newest_idx  = (oldest_q == '0) ? IDX_W'(win_q - CNT_W'(1)) : oldest_q - IDX_W'(1);

		// output register is free or being emptied this cycle
		out_load    = (state_q == ST_QOUT) && (!out_valid_q || out_ready);

		// push adds the count to the newest bin, query adds bins to the total
		if (state_q == ST_NEWEST_WR) begin
			add_a = ram_rdata;
			add_b = COUNT_W'(cnt_q);
		end else begin
			add_a = total_q;
			add_b = ram_rdata;
		end
		add_y = sat_add(add_a, add_b);

		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = pos_q;
		unique case (state_q) inside
			ST_CLEAR, ST_WIPE: begin
				ram_we = 1'b1;
			end
			ST_ADV: begin
				ram_we    = (rem_q != '0);
				ram_waddr = oldest_q;
			end
			ST_NEWEST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = newest_idx;
			end
			ST_NEWEST_WR: begin
				ram_we    = 1'b1;
				ram_wdata = add_y;
			end
			ST_QSUM: begin
				ram_re = (rem_q != '0);
			end
			default: begin
			end
		endcase
	end

	swerc_bin_ram #(
		.DEPTH  (MAX_BINS),
		.IDX_W  (IDX_W),
		.DATA_W (COUNT_W)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			win_q       <= win_clamp(WIN_RESET);
			oldest_q    <= '0;
			acc_q       <= '0;
			last_q      <= '0;
			pos_q       <= '0;
			rem_q       <= '0;
			pend_q      <= 1'b0;
			kind_q      <= KIND_PUSH;
			ts_q        <= '0;
			cnt_q       <= '0;
			diff_q      <= '0;
			sum_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= total_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				// new window: restart the counter and wipe the whole store
				win_q    <= win_clamp(cfg_data);
				oldest_q <= '0;
				acc_q    <= '0;
				last_q   <= '0;
				pos_q    <= '0;
				state_q  <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (in_valid) begin
							kind_q  <= kind;
							ts_q    <= timestamp;
							cnt_q   <= event_count;
							diff_q  <= {1'b0, timestamp} - {1'b0, last_q};
							state_q <= ST_ELAP;
						end
					end
					ST_CLEAR: begin
						pos_q <= pos_q + IDX_W'(1);
						if (pos_q == IDX_W'(MAX_BINS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_ELAP: begin
						sum_q   <= {diff_q[TS_W], diff_q} +
							{{(SUM_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
						state_q <= ST_DECIDE;
					end
					ST_DECIDE: begin
						total_q <= '0;
						pend_q  <= 1'b0;
						if (kind_q == KIND_PUSH) begin
							if (sum_neg) begin
								// time went backwards: no bins advance
								acc_q   <= acc_neg;
								state_q <= ST_NEWEST_RD;
							end else if (whole_ge) begin
								// a whole window passed: wipe the active bins
								acc_q    <= '0;
								oldest_q <= '0;
								pos_q    <= '0;
								rem_q    <= win_q;
								state_q  <= ST_WIPE;
							end else begin
								acc_q   <= acc_frac;
								rem_q   <= whole_w;
								state_q <= ST_ADV;
							end
						end else begin
							if ((sum_neg && past_second) || (!sum_neg && whole_ge)) begin
								state_q <= ST_QOUT;
							end else begin
								rem_q   <= win_q - skip_w;
								pos_q   <= start_pos;
								state_q <= ST_QSUM;
							end
						end
					end
					ST_ADV: begin
						// oldest bin is zeroed and becomes the newest
						if (rem_q == '0) begin
							state_q <= ST_NEWEST_RD;
						end else begin
							oldest_q <= oldest_next;
							rem_q    <= rem_q - CNT_W'(1);
						end
					end
					ST_WIPE: begin
						pos_q <= pos_q + IDX_W'(1);
						rem_q <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_NEWEST_RD;
						end
					end
					ST_NEWEST_RD: begin
						pos_q   <= newest_idx;
						state_q <= ST_NEWEST_WR;
					end
					ST_NEWEST_WR: begin
						last_q  <= ts_q;
						state_q <= ST_IDLE;
					end
					ST_QSUM: begin
						// one read issued and one word summed per cycle
						pend_q <= (rem_q != '0);
						if (rem_q != '0) begin
							pos_q <= pos_next;
							rem_q <= rem_q - CNT_W'(1);
						end
						if (pend_q) begin
							total_q <= add_y;
						end
						if (rem_q == '0 && !pend_q) begin
							state_q <= ST_QOUT;
						end
					end
					ST_QOUT: begin
						// waits here while the previous word is still held
						if (out_load) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign cfg_ready    = (state_q == ST_IDLE);
	assign in_ready     = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid    = out_valid_q;
	assign window_count = out_data_q;

endmodule

// File: sv/swerc_checker.sv
`include "assert_macros.svh"

module swerc_checker import swerc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COUNT_W-1:0] window_count
);

	// a waiting result word holds until taken
	`SWERC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(window_count))

	// an accepted word leaves the block busy after it is taken
	`SWERC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a result word only appears while the block is working on a query
	`SWERC_ASSERT_SAME(a_out_from_work, $rose(out_valid), !$past(in_ready))

	// a window write starts the clearing pass
	`SWERC_ASSERT_NEXT(a_clear_after_cfg, cfg_valid && cfg_ready, !in_ready)

endmodule

bind sliding_window_event_rate_counter swerc_checker u_swerc_checker (.*);

// File: sim/tb.sv
module tb;
	import swerc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     NBINS          = DEF_MAX_BINS;
	localparam int     FRAC           = DEF_FRAC_BITS;
	localparam longint ONE_S          = longint'(1) << FRAC;
	localparam longint ACC_FLOOR      = -(longint'(1) << 39);
	localparam longint MAX_COUNT      = 64'hFFFF_FFFF;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     DRAIN_CYCLES   = 200;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     PILE_PUSHES    = 64;
	localparam int     PHASE_ITEMS    = 210;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               kind = KIND_PUSH;
	logic [TS_W-1:0]    timestamp = '0;
	logic [EVT_W-1:0]   event_count = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COUNT_W-1:0] window_count;

	// model of the counter state
	logic [COUNT_W-1:0] bin_counts [NBINS];
	int                 oldest;
	longint             shift_acc;
	logic [TS_W-1:0]    last_ts;
	logic [CFG_W-1:0]   win_reg;

	// window totals owed by the block, oldest query first
	logic [COUNT_W-1:0] query_totals [$];
	logic [COUNT_W-1:0] want;
	int                 errors = 0;
	int                 quiet_cycles = 0;

	// sender pacing
	int gap_max = 0;
	int burst_left = 0;

	// receiver stall pattern and the long hold-off
	logic hold_tog = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   run_left = 0;

	sliding_window_event_rate_counter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.timestamp    (timestamp),
		.event_count  (event_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_count (window_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic int active_window();
		int w;
		w = int'(win_reg);
		if (w < 1) w = 1;
		if (w > NBINS) w = NBINS;
		return w;
	endfunction

	function automatic void restart_counter();
		foreach (bin_counts[i]) bin_counts[i] = '0;
		oldest = 0;
		shift_acc = 0;
		last_ts = '0;
	endfunction

	// accumulator plus time since the last push, in 2^-16 s units
	function automatic longint elapsed_since_push(input logic [TS_W-1:0] ts);
		longint now_t;
		longint prev_t;
		now_t = longint'(ts);
		prev_t = longint'(last_ts);
		return shift_acc + now_t - prev_t;
	endfunction

	function automatic void advance_and_add(input logic [TS_W-1:0] ts,
			input logic [EVT_W-1:0] n);
		int             w;
		longint         el;
		longint         whole;
		int             newest;
		logic [COUNT_W:0] t;
		w = active_window();
		el = elapsed_since_push(ts);
		if (oldest >= w) oldest = 0;
		if (el < 0) begin
			// time went backwards: no bins move, accumulator goes negative
			shift_acc = (el < ACC_FLOOR) ? ACC_FLOOR : el;
		end else begin
			whole = el >>> FRAC;
			if (whole >= w) begin
				// a whole window passed, start over from bin 0
				restart_counter();
			end else begin
				for (longint k = 0; k < whole; k++) begin
					bin_counts[oldest] = '0;
					oldest = (oldest + 1 >= w) ? 0 : oldest + 1;
				end
				shift_acc = el - (whole <<< FRAC);
			end
		end
		newest = (oldest == 0) ? w - 1 : oldest - 1;
		t = {1'b0, bin_counts[newest]} + (COUNT_W+1)'(n);
		bin_counts[newest] = t[COUNT_W] ? '1 : t[COUNT_W-1:0];
		last_ts = ts;
	endfunction

	function automatic logic [COUNT_W-1:0] window_total(input logic [TS_W-1:0] ts);
		int     w;
		longint el;
		longint age;
		int     front;
		int     pos;
		longint total;
		w = active_window();
		el = elapsed_since_push(ts);
		front = (oldest < w) ? oldest : 0;
		if (el < 0) begin
			if (-el >= ONE_S) return '0;
			age = 0;
		end else begin
			age = el >>> FRAC;
			if (age >= w) return '0;
		end
		total = 0;
		for (int i = int'(age); i < w; i++) begin
			pos = front + i;
			if (pos >= w) pos -= w;
			total += longint'(bin_counts[pos]);
			if (total > MAX_COUNT) total = MAX_COUNT;
		end
		return total[COUNT_W-1:0];
	endfunction

	// -------------------------------------------------------------- drivers

	// bursts of random length separated by random gaps
	task automatic pace();
		int gap;
		if (gap_max == 0) return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 16);
		gap = $urandom_range(1, gap_max);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// offer one word and hold it until the block takes it
	task automatic send_word(input logic k, input longint ts,
			input int unsigned n);
		logic [TS_W-1:0]  ts_w;
		logic [EVT_W-1:0] n_w;
		ts_w = TS_W'(ts);
		n_w = EVT_W'(n);
		pace();
		in_valid <= 1'b1;
		kind <= k;
		timestamp <= ts_w;
		event_count <= n_w;
		do @(posedge clk); while (!in_ready);
		if (k == KIND_PUSH) advance_and_add(ts_w, n_w);
		else query_totals = {query_totals, window_total(ts_w)};
	endtask

	// stop sending, let every owed word come back, then let a push finish
	task automatic drain();
		in_valid <= 1'b0;
		while (query_totals.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] w);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		// a write restarts the counter
		win_reg = w;
		restart_counter();
	endtask

	// ---------------------------------------------------------------- tests

	// reset window of 60 s, backwards time, -1 s and window boundaries,
	// extreme timestamps and the accumulator floor
	task automatic test_default_window();
		longint top_ts;
		top_ts = (longint'(1) << TS_W) - 1;
		gap_max = 6;
		send_word(KIND_QUERY, 0, 65535);
		send_word(KIND_PUSH, 100 * ONE_S, 65535);
		send_word(KIND_PUSH, 100 * ONE_S + ONE_S / 2, 3);
		send_word(KIND_QUERY, 100 * ONE_S + ONE_S / 2, $urandom);
		send_word(KIND_QUERY, 99 * ONE_S, $urandom);
		send_word(KIND_QUERY, 99 * ONE_S + 1, $urandom);
		send_word(KIND_QUERY, 160 * ONE_S - 1, $urandom);
		send_word(KIND_QUERY, 160 * ONE_S, $urandom);
		send_word(KIND_PUSH, 90 * ONE_S, 5);
		send_word(KIND_QUERY, 90 * ONE_S, $urandom);
		send_word(KIND_PUSH, 101 * ONE_S, 7);
		send_word(KIND_QUERY, 101 * ONE_S + 1, $urandom);
		send_word(KIND_QUERY, 160 * ONE_S, $urandom);
		send_word(KIND_QUERY, 161 * ONE_S - 1, $urandom);
		send_word(KIND_QUERY, 161 * ONE_S, $urandom);
		send_word(KIND_PUSH, top_ts, 1);
		send_word(KIND_QUERY, top_ts, $urandom);
		send_word(KIND_QUERY, 0, $urandom);
		// huge step back pins the accumulator at its floor
		send_word(KIND_PUSH, 0, 0);
		send_word(KIND_QUERY, (longint'(1) << 39) + ONE_S / 2, $urandom);
		send_word(KIND_QUERY, (longint'(1) << 39) - 1, $urandom);
		send_word(KIND_QUERY, (longint'(1) << 39) - ONE_S, $urandom);
	endtask

	// shortest and longest window, and values outside 1..64
	task automatic test_window_limits();
		gap_max = 4;
		write_window(7'd1);
		send_word(KIND_PUSH, 5 * ONE_S, 9);
		send_word(KIND_PUSH, 6 * ONE_S - 1, 1);
		send_word(KIND_QUERY, 6 * ONE_S - 1, $urandom);
		send_word(KIND_QUERY, 6 * ONE_S, $urandom);
		send_word(KIND_PUSH, 6 * ONE_S, 4);
		send_word(KIND_QUERY, 6 * ONE_S, $urandom);
		write_window(7'd64);
		for (int i = 0; i < 6; i++) send_word(KIND_PUSH, (1000 + i) * ONE_S, i + 1);
		send_word(KIND_QUERY, 1069 * ONE_S - 1, $urandom);
		send_word(KIND_QUERY, 1069 * ONE_S, $urandom);
		send_word(KIND_QUERY, 1005 * ONE_S, $urandom);
		// zero acts as one bin
		write_window(7'd0);
		send_word(KIND_PUSH, 3 * ONE_S, 2);
		send_word(KIND_QUERY, 4 * ONE_S - 1, $urandom);
		send_word(KIND_QUERY, 4 * ONE_S, $urandom);
		// above the store size acts as 64 bins
		write_window(7'd127);
		send_word(KIND_PUSH, 2 * ONE_S, 8);
		send_word(KIND_PUSH, 65 * ONE_S, 1);
		send_word(KIND_QUERY, 65 * ONE_S, $urandom);
		send_word(KIND_QUERY, 66 * ONE_S, $urandom);
	endtask

	// receiver holds off while queries keep coming, so the input stalls
	task automatic test_output_hold();
		write_window(7'd64);
		gap_max = 0;
		for (int i = 0; i < 8; i++)
			send_word(KIND_PUSH, (200 + i) * ONE_S + $urandom_range(0, ONE_S - 1), $urandom);
		hold_tog <= ~hold_tog;
		for (int i = 0; i < 16; i++)
			send_word(KIND_QUERY, longint'(last_ts) + $urandom_range(0, 8 * ONE_S), $urandom);
	endtask

	// pile full counts into one bin back to back, then sums across the ring
	task automatic test_bin_pileup();
		write_window(7'd2);
		gap_max = 0;
		repeat (PILE_PUSHES) send_word(KIND_PUSH, 7 * ONE_S, 65535);
		send_word(KIND_QUERY, 7 * ONE_S, $urandom);
		send_word(KIND_PUSH, 8 * ONE_S, 1);
		send_word(KIND_QUERY, 8 * ONE_S + ONE_S / 2, $urandom);
		send_word(KIND_QUERY, 9 * ONE_S, $urandom);
	endtask

	// mostly small steps around the last push so the ring really turns,
	// some steps back, some jumps past the window, some anywhere at all
	task automatic random_phase(input int n_items);
		int              w;
		int              sel;
		longint          d;
		longint          j;
		logic            k;
		longint          ts;
		int unsigned     cnt;
		w = active_window();
		for (int i = 0; i < n_items; i++) begin
			cnt = $urandom;
			sel = $urandom_range(0, 15);
			if (sel == 0) cnt = 65535;
			else if (sel == 1) cnt = 0;
			k = ($urandom_range(0, 99) < 55) ? KIND_PUSH : KIND_QUERY;
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				ts = {$urandom, $urandom};
			end else begin
				if (k == KIND_PUSH) begin
					if (sel <= 2) begin
						d = $urandom_range(0, 3 * ONE_S);
						d = -d;
					end else if (sel <= 5) begin
						d = $urandom_range(0, (w + 2) * ONE_S);
					end else if (sel <= 8) begin
						d = $urandom_range(0, 3);
						d = d * ONE_S;
					end else begin
						d = $urandom_range(0, 2 * ONE_S);
					end
				end else begin
					if (sel <= 6) begin
						// whole-second edges, one unit either side
						d = $urandom_range(0, w + 1);
						j = $urandom_range(0, 2);
						d = (d - 1) * ONE_S + j - 1;
					end else begin
						d = $urandom_range(0, (w + 3) * ONE_S);
						d = d - 2 * ONE_S;
					end
				end
				ts = longint'(last_ts) + d;
			end
			send_word(k, ts, cnt);
		end
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] plan [8];
		plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd0, 7'd0, 7'd0};
		plan[5] = CFG_W'($urandom_range(3, 63));
		plan[6] = CFG_W'($urandom_range(3, 63));
		plan[7] = CFG_W'($urandom_range(3, 63));
		for (int p = 0; p < 8; p++) begin
			write_window(plan[p]);
			// every third phase runs without sender gaps
			gap_max = (p % 3 == 0) ? 0 : 12;
			random_phase(PHASE_ITEMS);
		end
	endtask

	// ------------------------------------------------------------- sequence

	initial begin
		win_reg = WIN_RESET;
		restart_counter();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_window_limits();
		test_output_hold();
		test_bin_pileup();
		test_random_traffic();
		drain();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// ------------------------------------------------------------- receiver

	// random stalls, free-running stretches, and the requested long hold-off
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			run_left <= 0;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (run_left != 0) begin
			run_left <= run_left - 1;
		end else begin
			case ($urandom_range(0, 5)) inside
				0: begin
					out_ready <= 1'b1;
					run_left <= $urandom_range(100, 300);
				end
				1, 2: begin
					out_ready <= 1'b0;
					run_left <= $urandom_range(0, 7);
				end
				default: begin
					out_ready <= 1'b1;
					run_left <= $urandom_range(0, 30);
				end
			endcase
		end
	end

	// each accepted word against the oldest owed window total
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (query_totals.size() == 0) begin
				$display("%0t: window_count word with no query owed, expected none, actual %0d",
					$time, window_count);
				errors++;
			end else begin
				want = query_totals.pop_front();
				if (window_count !== want) begin
					$display("%0t: window_count mismatch, expected %0d, actual %0d",
						$time, want, window_count);
					errors++;
				end
			end
		end
	end

	// nothing accepted on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

// File: filelist.f
+incdir+sv
sv/swerc_pkg.sv
sv/swerc_bin_ram.sv
sv/sliding_window_event_rate_counter.sv
sv/swerc_checker.sv
sim/tb.sv
